// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the mouse-keys velocity RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MKV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mkv assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mkv assertion failed");

`endif

// ===== rtl/mkv_pkg.sv =====
// Shared types, codes and direction tables for the mouse-keys velocity unit.
// No dependencies; used by all rtl modules through scoped names.
package mkv_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXV  = 2'd2;

  localparam logic [3:0] ACT_NONE         = 4'd0;
  localparam logic [3:0] ACT_LEFT_CLICK   = 4'd0;
  localparam logic [3:0] ACT_MIDDLE_CLICK = 4'd1;
  localparam logic [3:0] ACT_RIGHT_CLICK  = 4'd2;
  localparam logic [3:0] ACT_LEFT         = 4'd3;
  localparam logic [3:0] ACT_LEFT_UP      = 4'd4;
  localparam logic [3:0] ACT_LEFT_DOWN    = 4'd5;
  localparam logic [3:0] ACT_RIGHT        = 4'd6;
  localparam logic [3:0] ACT_RIGHT_UP     = 4'd7;
  localparam logic [3:0] ACT_RIGHT_DOWN   = 4'd8;
  localparam logic [3:0] ACT_UP           = 4'd9;
  localparam logic [3:0] ACT_DOWN         = 4'd10;

  localparam logic KIND_BUTTON = 1'b0;
  localparam logic KIND_MOVE   = 1'b1;

  localparam logic [2:0] BTN_LEFT   = 3'b001;
  localparam logic [2:0] BTN_RIGHT  = 3'b010;
  localparam logic [2:0] BTN_MIDDLE = 3'b100;

  typedef struct packed {
    logic [7:0] accel_step;
    logic [7:0] drag_step;
    logic [6:0] max_velocity;
  } cfg_t;

  typedef struct packed {
    logic              report_kind;
    logic [2:0]        button_mask;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
  } res_t;

  // Direction sign per held action: +1, -1 or 0.
  function automatic logic signed [1:0] dir_x(input logic [3:0] act);
    logic signed [1:0] d;
    unique case (act)
      ACT_LEFT, ACT_LEFT_UP, ACT_LEFT_DOWN:    d = -2'sd1;
      ACT_RIGHT, ACT_RIGHT_UP, ACT_RIGHT_DOWN: d = 2'sd1;
      default:                                 d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] dir_y(input logic [3:0] act);
    logic signed [1:0] d;
    unique case (act)
      ACT_LEFT_UP, ACT_RIGHT_UP, ACT_UP:       d = -2'sd1;
      ACT_LEFT_DOWN, ACT_RIGHT_DOWN, ACT_DOWN: d = 2'sd1;
      default:                                 d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] click_bit(input logic [3:0] act);
    logic [2:0] b;
    unique case (act)
      ACT_LEFT_CLICK:   b = BTN_LEFT;
      ACT_MIDDLE_CLICK: b = BTN_MIDDLE;
      default:          b = BTN_RIGHT;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/mkv_cfg.sv =====
// Configuration register file: accel step, drag step and velocity clamp.
// Depends on mkv_pkg for the register indexes and cfg_t.
module mkv_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mkv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mkv_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mkv_pkg::cfg_t                  cfg
);

  mkv_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_step   <= 8'd77;
      cfg_r.drag_step    <= 8'd38;
      cfg_r.max_velocity <= 7'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mkv_pkg::CFG_ACCEL: cfg_r.accel_step   <= cfg_wdata[7:0];
        mkv_pkg::CFG_DRAG:  cfg_r.drag_step    <= cfg_wdata[7:0];
        mkv_pkg::CFG_MAXV:  cfg_r.max_velocity <= cfg_wdata[6:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/mkv_axis.sv =====
// One axis of the velocity update: accelerate, drag, clamp, whole part.
// Depends on mkv_pkg for cfg_t.
module mkv_axis #(
  parameter int FRAC_BITS = mkv_pkg::FRAC_BITS_DEF
) (
  input  logic signed [FRAC_BITS+7:0] vel,
  input  logic signed [1:0]           dir,
  input  mkv_pkg::cfg_t               cfg,
  output logic signed [FRAC_BITS+7:0] vel_nxt,
  output logic                        inside_drag,
  output logic signed [7:0]           move
);

  localparam int VW = FRAC_BITS + 8;
  localparam int EW = VW + 2;

  logic signed [EW-1:0] v_e, acc_e, drg_e, neg_drg_e, lim_e, neg_lim_e;
  logic signed [EW-1:0] s1, s2, s3;
  logic                 s1_pos, s1_neg, s3_neg;
  logic        [EW-1:0] mag;
  logic        [7:0]    whole;

  always_comb begin
    v_e       = {{2{vel[VW-1]}}, vel};
    acc_e     = $signed({{(EW-8){1'b0}}, cfg.accel_step});
    drg_e     = $signed({{(EW-8){1'b0}}, cfg.drag_step});
    neg_drg_e = -drg_e;
    lim_e     = $signed({3'b000, cfg.max_velocity, {FRAC_BITS{1'b0}}});
    neg_lim_e = -lim_e;

    // accelerate along the held direction
    if (dir == 2'sd1)       s1 = v_e + acc_e;
    else if (dir == -2'sd1) s1 = v_e - acc_e;
    else                    s1 = v_e;

    // drag toward zero, overshoot allowed
    s1_neg = s1[EW-1];
    s1_pos = !s1[EW-1] && (s1 != '0);
    if (s1_pos)      s2 = s1 - drg_e;
    else if (s1_neg) s2 = s1 + drg_e;
    else             s2 = s1;

    // clamp to the configured limit
    if (s2 > lim_e)          s3 = lim_e;
    else if (s2 < neg_lim_e) s3 = neg_lim_e;
    else                     s3 = s2;

    vel_nxt     = s3[VW-1:0];
    inside_drag = (s3 < drg_e) && (s3 > neg_drg_e);

    // truncate toward zero: negate, shift, negate back
    s3_neg = s3[EW-1];
    mag    = s3_neg ? EW'(-s3) : EW'(s3);
    whole  = mag[FRAC_BITS+7:FRAC_BITS];
    move   = s3_neg ? $signed(~whole + 8'd1) : $signed(whole);
  end

endmodule

// ===== rtl/mkv_core.sv =====
// Command decode and pointer state: buttons, held direction, ticker, velocity.
// Depends on mkv_pkg and mkv_axis.
module mkv_core #(
  parameter int FRAC_BITS = mkv_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [1:0]     command,
  input  logic [3:0]     action,
  input  mkv_pkg::cfg_t  cfg,
  output logic           res_valid,
  output mkv_pkg::res_t  res
);

  localparam int VW = FRAC_BITS + 8;

  logic signed [VW-1:0] vel_x_r, vel_y_r, vel_x_nxt, vel_y_nxt;
  logic signed [VW-1:0] upd_x, upd_y;
  logic [3:0]           held_r, held_nxt;
  logic                 running_r, running_nxt;
  logic [2:0]           buttons_r, buttons_nxt;
  logic                 in_x, in_y;
  logic signed [7:0]    mv_x, mv_y;

  mkv_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .vel(vel_x_r), .dir(mkv_pkg::dir_x(held_r)), .cfg(cfg),
    .vel_nxt(upd_x), .inside_drag(in_x), .move(mv_x)
  );

  mkv_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .vel(vel_y_r), .dir(mkv_pkg::dir_y(held_r)), .cfg(cfg),
    .vel_nxt(upd_y), .inside_drag(in_y), .move(mv_y)
  );

  always_comb begin
    vel_x_nxt       = vel_x_r;
    vel_y_nxt       = vel_y_r;
    held_nxt        = held_r;
    running_nxt     = running_r;
    buttons_nxt     = buttons_r;
    res_valid       = 1'b0;
    res.report_kind = mkv_pkg::KIND_BUTTON;
    res.button_mask = buttons_r;
    res.move_x      = '0;
    res.move_y      = '0;
    unique case (mkv_pkg::cmd_t'(command))
      mkv_pkg::CMD_PRESS, mkv_pkg::CMD_RELEASE: begin
        if (action <= mkv_pkg::ACT_RIGHT_CLICK) begin
          if (command == mkv_pkg::CMD_PRESS) buttons_nxt = buttons_r | mkv_pkg::click_bit(action);
          else                               buttons_nxt = buttons_r & ~mkv_pkg::click_bit(action);
          res_valid       = 1'b1;
          res.button_mask = buttons_nxt;
        end else if (action <= mkv_pkg::ACT_DOWN) begin
          if (command == mkv_pkg::CMD_PRESS) begin
            held_nxt    = action;
            running_nxt = 1'b1;
          end else begin
            held_nxt = mkv_pkg::ACT_NONE;
          end
        end
      end
      mkv_pkg::CMD_TICK: begin
        if (running_r) begin
          vel_x_nxt = upd_x;
          vel_y_nxt = upd_y;
          if (in_x && in_y && (held_r == mkv_pkg::ACT_NONE)) begin
            running_nxt = 1'b0;  // stop quietly, keep the residual velocity
          end else begin
            res_valid       = 1'b1;
            res.report_kind = mkv_pkg::KIND_MOVE;
            res.move_x      = mv_x;
            res.move_y      = mv_y;
          end
        end
      end
      default: ;  // ignore unknown command
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_x_r   <= '0;
      vel_y_r   <= '0;
      held_r    <= mkv_pkg::ACT_NONE;
      running_r <= 1'b0;
      buttons_r <= '0;
    end else if (en) begin
      vel_x_r   <= vel_x_nxt;
      vel_y_r   <= vel_y_nxt;
      held_r    <= held_nxt;
      running_r <= running_nxt;
      buttons_r <= buttons_nxt;
    end
  end

endmodule

// ===== rtl/mouse_keys_velocity_unit.sv =====
// Top level of the mouse-keys velocity unit: input stage, core, result register.
// Depends on mkv_pkg, mkv_cfg, mkv_core and assert_macros.svh.
//
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/tready     tuser = command, tdata = action
// out_     out  out_tvalid/tready    tuser = report_kind, tdata = mask, move x, move y
// cfg_     in   cfg_we               cfg_index, cfg_wdata (no read-back)
//
// One item per cycle sustained while out_tready is high. An accepted word is
// held in the input stage; the core updates state and computes the result, and
// the result register presents it the cycle after. The single velocity/state
// update path in mkv_core sets the rate. Reset (rst_n low, synchronous) clears
// all state and loads the register defaults. A stalled result holds the result
// register; the input stage still takes one word while it is empty.
`include "assert_macros.svh"

module mouse_keys_velocity_unit #(
  parameter int FRAC_BITS = mkv_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [3:0] action, [7:4] zero
  input  logic [1:0]                     in_tuser,   // [1:0] command
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // [2:0] button_mask, [10:3] move_x,
                                                     // [18:11] move_y, [23:19] zero
  output logic                           out_tuser,  // [0] report_kind
  // configuration write port
  input  logic                           cfg_we,
  input  logic [mkv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mkv_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mkv_pkg::cfg_t cfg;
  mkv_pkg::res_t core_res, out_res_r;
  logic          core_valid;

  logic          s1_valid_r;
  logic [1:0]    s1_cmd_r;
  logic [3:0]    s1_act_r;
  logic          out_valid_r;
  logic          out_free, advance, in_fire;

  mkv_cfg u_cfg (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .cfg(cfg)
  );

  // Output register can take a result when empty or being drained.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  // Input stage: hold the word until the core consumes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= in_tuser;
      s1_act_r <= in_tdata[3:0];
    end
  end

  // State advances only when the word leaves the input stage.
  mkv_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk(clk), .rst_n(rst_n), .en(advance),
    .command(s1_cmd_r), .action(s1_act_r), .cfg(cfg),
    .res_valid(core_valid), .res(core_res)
  );

  // Result register: load on advance, drop words that make no report.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && core_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.report_kind;
  assign out_tdata  = {5'b00000, out_res_r.move_y, out_res_r.move_x, out_res_r.button_mask};

  // A button report never carries motion.
  `MKV_ASSERT_IMPL(a_button_no_move, clk, rst_n,
    out_tvalid && (out_tuser == mkv_pkg::KIND_BUTTON), out_tdata[18:3] == 16'd0)
  // Moves are clamped to plus or minus 127 counts.
  `MKV_ASSERT_IMPL(a_move_range, clk, rst_n,
    out_tvalid, (out_tdata[10:3] != 8'h80) && (out_tdata[18:11] != 8'h80))
  // A full input stage behind a stalled result blocks new words.
  `MKV_ASSERT_IMPL(a_stall_blocks, clk, rst_n,
    s1_valid_r && out_valid_r && !out_tready, !in_tready)
  // An accepted word always lands in the input stage.
  `MKV_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_fire, s1_valid_r)

endmodule
